// File: hdl/dbkt_pkg.sv
// package for the draw-batch key table: command codes, key and result types,
// controller states and the controller/datapath command and status structs
// no dependencies
package dbkt_pkg;

    localparam int MAX_SLOTS = 32;
    localparam int GRP_W     = 5;
    localparam int SKEY_W    = 48;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_SORT  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_command;

    typedef enum logic {
        KIND_ADD   = 1'b0,
        KIND_ENTRY = 1'b1
    } t_kind;

    typedef struct packed {
        logic signed [15:0] depth;
        logic [15:0]        shader;
        logic [15:0]        texture;
    } t_key;

    typedef struct packed {
        logic [1:0] command;
        t_key       key;
    } t_item;

    typedef struct packed {
        t_kind            reply_kind;
        logic [GRP_W-1:0] group_index;
        logic             is_new;
        logic             table_full;
        t_key             entry;
        logic             last;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE,
        ST_REPLY,
        ST_SORT,
        ST_LOAD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic match;
        logic add;
        logic clear;
        logic sort_init;
        logic sort_step;
        logic emit_init;
        logic emit_load;
        logic emit_next;
    } t_dp_cmd;

    typedef struct packed {
        t_command cmd;
        logic     count_zero;
        logic     phase_done;
        logic     emit_last;
    } t_dp_stat;

    // depth is signed: flipping its sign bit makes the whole key compare unsigned
    function automatic logic [SKEY_W-1:0] sort_key(input t_key k);
        sort_key = {~k.depth[15], k.depth[14:0], k.shader, k.texture};
    endfunction

endpackage

// File: hdl/dbkt_cmd_if.sv
// request channel of the draw-batch key table: valid/ready plus command and key
// no dependencies
interface dbkt_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [15:0] depth_key;
    logic [15:0]        shader_id;
    logic [15:0]        texture_id;

    modport source(output valid, output command, output depth_key, output shader_id,
                   output texture_id, input ready);
    modport sink(input valid, input command, input depth_key, input shader_id,
                 input texture_id, output ready);
endinterface

// File: hdl/dbkt_res_if.sv
// result channel of the draw-batch key table: valid/ready plus reply fields
// no dependencies
interface dbkt_res_if;
    logic               valid;
    logic               ready;
    logic               reply_kind;
    logic [4:0]         group_index;
    logic               is_new;
    logic               table_full;
    logic signed [15:0] entry_depth;
    logic [15:0]        entry_shader;
    logic [15:0]        entry_texture;
    logic               last;

    modport source(output valid, output reply_kind, output group_index, output is_new,
                   output table_full, output entry_depth, output entry_shader,
                   output entry_texture, output last, input ready);
    modport sink(input valid, input reply_kind, input group_index, input is_new,
                 input table_full, input entry_depth, input entry_shader,
                 input entry_texture, input last, output ready);
endinterface

// File: hdl/dbkt_ctrl.sv
// controller of the draw-batch key table: sequences match, insert, sort and emit
// depends on dbkt_pkg
module dbkt_ctrl
    import dbkt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MATCH;
            end
            ST_MATCH: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                unique case (i_stat.cmd)
                    CMD_ADD:  n_state = ST_REPLY;
                    CMD_SORT: n_state = i_stat.count_zero ? ST_IDLE : ST_SORT;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_REPLY: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            ST_SORT: begin
                if (i_stat.phase_done) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_ready) n_state = i_stat.emit_last ? ST_IDLE : ST_LOAD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_MATCH: begin
                o_cmd.match = 1'b1;
            end
            ST_DECIDE: begin
                o_cmd.add       = (i_stat.cmd == CMD_ADD);
                o_cmd.clear     = (i_stat.cmd == CMD_CLEAR);
                o_cmd.sort_init = (i_stat.cmd == CMD_SORT);
            end
            ST_REPLY: begin
                o_out_valid = 1'b1;
            end
            ST_SORT: begin
                o_cmd.sort_step = 1'b1;
                o_cmd.emit_init = i_stat.phase_done;
            end
            ST_LOAD: begin
                o_cmd.emit_load = 1'b1;
            end
            ST_EMIT: begin
                o_out_valid     = 1'b1;
                o_cmd.emit_next = i_out_ready && !i_stat.emit_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/dbkt_dp.sv
// datapath of the draw-batch key table: key store, parallel match,
// odd-even transposition sort network and result register
// depends on dbkt_pkg
module dbkt_dp
    import dbkt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_item    i_item,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_res     o_res
);

    localparam int CAP   = (TABLE_DEPTH > MAX_SLOTS) ? MAX_SLOTS : TABLE_DEPTH;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;

    t_key             r_key [CAP];
    logic [GRP_W-1:0] r_grp [CAP];
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_phase;
    logic [IDX_W-1:0] r_idx;
    t_item            r_in;
    logic [CAP-1:0]   r_hit;
    t_res             r_res;

    logic [CAP-1:0]   n_hit;
    logic             hit_any;
    logic [GRP_W-1:0] hit_grp;
    logic             is_full;
    logic             do_insert;
    logic [CAP-1:0]   swap;
    t_key             sorted_key [CAP];
    logic [GRP_W-1:0] sorted_grp [CAP];

    // compare the held key against every live entry at once
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            n_hit[i] = (CNT_W'(i) < r_count) && (r_key[i] == r_in.key);
        end
    end

    // live keys are distinct, so at most one hit bit is set
    always_comb begin
        hit_grp = '0;
        for (int i = 0; i < CAP; i++) begin
            hit_grp = hit_grp | (r_hit[i] ? r_grp[i] : '0);
        end
    end

    assign hit_any   = |r_hit;
    assign is_full   = (r_count == CNT_W'(CAP));
    assign do_insert = i_cmd.add && !hit_any && !is_full;

    // one phase of compare-exchange on neighbor pairs of the current parity
    always_comb begin
        swap = '0;
        for (int k = 0; k < CAP - 1; k++) begin
            swap[k] = (1'(k) == r_phase[0]) && (CNT_W'(k + 1) < r_count) &&
                      (sort_key(r_key[k]) > sort_key(r_key[k + 1]));
        end
        for (int i = 0; i < CAP; i++) begin
            sorted_key[i] = r_key[i];
            sorted_grp[i] = r_grp[i];
        end
        for (int k = 0; k < CAP - 1; k++) begin
            if (swap[k]) begin
                sorted_key[k]     = r_key[k + 1];
                sorted_key[k + 1] = r_key[k];
                sorted_grp[k]     = r_grp[k + 1];
                sorted_grp[k + 1] = r_grp[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (do_insert) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.sort_init) begin
                r_phase <= '0;
            end else if (i_cmd.sort_step) begin
                r_phase <= r_phase + IDX_W'(1);
            end
            if (i_cmd.emit_init) begin
                r_idx <= '0;
            end else if (i_cmd.emit_next) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_item;
        end
        if (i_cmd.match) begin
            r_hit <= n_hit;
        end
        if (do_insert) begin
            r_key[r_count[IDX_W-1:0]] <= r_in.key;
            r_grp[r_count[IDX_W-1:0]] <= GRP_W'(r_count);
        end
        if (i_cmd.sort_step) begin
            for (int i = 0; i < CAP; i++) begin
                r_key[i] <= sorted_key[i];
                r_grp[i] <= sorted_grp[i];
            end
        end
        if (i_cmd.add) begin
            r_res.reply_kind  <= KIND_ADD;
            r_res.group_index <= hit_any ? hit_grp : (is_full ? '0 : GRP_W'(r_count));
            r_res.is_new      <= !hit_any && !is_full;
            r_res.table_full  <= !hit_any && is_full;
            r_res.entry       <= r_in.key;
            r_res.last        <= 1'b1;
        end else if (i_cmd.emit_load) begin
            r_res.reply_kind  <= KIND_ENTRY;
            r_res.group_index <= r_grp[r_idx];
            r_res.is_new      <= 1'b0;
            r_res.table_full  <= 1'b0;
            r_res.entry       <= r_key[r_idx];
            r_res.last        <= o_stat.emit_last;
        end
    end

    assign o_stat.cmd        = t_command'(r_in.command);
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.phase_done = (CNT_W'(r_phase) == r_count - CNT_W'(1));
    assign o_stat.emit_last  = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign o_res             = r_res;

endmodule

// File: hdl/draw_batch_key_table_core.sv
// top level of the draw-batch key table: controller plus datapath
// depends on dbkt_pkg, dbkt_cmd_if, dbkt_res_if, dbkt_ctrl, dbkt_dp
//
// i_cmd carries one request at a time: add a key, sort and emit the table,
// or clear it. o_res returns the results. an add always gives one reply
// (matched group, new group with is_new, or table_full when no room is left).
// a sort gives one result per stored entry in ascending depth, shader,
// texture order, with last on the final one; an empty table gives none.
// a clear gives no result.
// timing: a request is taken only while the block is idle. an add raises its
// reply valid after the match and decide states, and the next request is
// taken once a ready receiver has taken the reply and the block is idle again.
// a sort of n entries runs n phases of the odd-even transposition
// network (one neighbor-pair phase per cycle), then emits each entry through
// the load and emit states, loading the next only once the receiver takes it.
// clear and unused codes return to idle after the match and decide states.
// reset empties the table at once; the key store itself is not cleared.
// when the receiver stalls the result register holds and no request is taken.
module draw_batch_key_table_core
    import dbkt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dbkt_cmd_if.sink          i_cmd,
    dbkt_res_if.source        o_res
);

    t_item    item;
    t_res     res;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;
    logic     out_valid;

    assign item.command     = i_cmd.command;
    assign item.key.depth   = i_cmd.depth_key;
    assign item.key.shader  = i_cmd.shader_id;
    assign item.key.texture = i_cmd.texture_id;
    assign i_cmd.ready      = in_ready;

    dbkt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    dbkt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_res   (res)
    );

    assign o_res.valid         = out_valid;
    assign o_res.reply_kind    = res.reply_kind;
    assign o_res.group_index   = res.group_index;
    assign o_res.is_new        = res.is_new;
    assign o_res.table_full    = res.table_full;
    assign o_res.entry_depth   = res.entry.depth;
    assign o_res.entry_shader  = res.entry.shader;
    assign o_res.entry_texture = res.entry.texture;
    assign o_res.last          = res.last;

endmodule

// File: hdl/dbkt_checker.sv
// port-level checks for the draw-batch key table and the bind that attaches them
// depends on draw_batch_key_table_core
module dbkt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cmd_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_reply_kind,
    input logic i_is_new,
    input logic i_table_full,
    input logic i_last
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // one request at a time: nothing taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_cmd_ready)
        else $error("request taken while a result is pending");

    // an add reply is always the only result of its request
    a_add_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_reply_kind |-> i_last)
        else $error("add reply without last");

    a_new_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !(i_is_new && i_table_full))
        else $error("reply both new and full");

    // sorted entries carry no add flags
    a_entry_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_reply_kind |-> !i_is_new && !i_table_full)
        else $error("sorted entry with add flags");

endmodule

bind draw_batch_key_table_core dbkt_checker u_dbkt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_ready  (i_cmd.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_reply_kind (o_res.reply_kind),
    .i_is_new     (o_res.is_new),
    .i_table_full (o_res.table_full),
    .i_last       (o_res.last)
);
